// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle; needs clk and rst_n in scope.
`define SITS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sits assertion failed");

// Implication checked in the next cycle.
`define SITS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sits assertion failed");

`endif

// ===== hw/rtl/sits_pkg.sv =====
package sits_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int MAX_INTERVALS    = 65535;

  // datapath widths
  localparam int A_W   = 32;  // limits
  localparam int D_W   = 33;  // upper - lower
  localparam int N_W   = 17;  // panel count
  localparam int I_W   = 18;  // sample index, up to count + 1
  localparam int DN_W  = 19;  // 3 * count
  localparam int Z_W   = 36;  // CORDIC x, y, angle
  localparam int T_W   = 52;  // weighted sine sum
  localparam int NUM_W = 54;  // divider numerator
  localparam int DEN_W = 19;  // divider denominator
  localparam int PQ_W  = 35;  // sample offset quotient
  localparam int PR_W  = 19;  // sample offset remainder
  localparam int M_W   = 35;  // mean sine value, Q32
  localparam int P_W   = 68;  // mean times span
  localparam int OUT_W = 40;

  localparam logic [32:0] HP_Q32    = 33'd6746518852;  // pi/2 in Q32
  localparam logic [32:0] HP_HALF   = 33'd3373259426;
  localparam logic signed [Z_W-1:0] INV_GAIN = 36'sd2608131496;

  typedef struct packed {
    logic load;
    logic div_step;
    logic div_mean;
    logic pt_init;
    logic red_start;
    logic cor_start;
    logic mul_start;
    logic out_load;
  } sits_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic red_busy;
    logic buf_full;
    logic cor_busy;
    logic all_issued;
    logic mul_busy;
  } sits_stat_t;

  // atan(2^-i) in Q32
  function automatic logic [Z_W-1:0] atan_q32(input logic [5:0] i);
    logic [Z_W-1:0] v;
    case (i)
      6'd0:  v = 36'd3373259426;
      6'd1:  v = 36'd1991351318;
      6'd2:  v = 36'd1052175346;
      6'd3:  v = 36'd534100635;
      6'd4:  v = 36'd268086748;
      6'd5:  v = 36'd134174063;
      6'd6:  v = 36'd67103403;
      6'd7:  v = 36'd33553749;
      6'd8:  v = 36'd16777131;
      6'd9:  v = 36'd8388597;
      6'd10: v = 36'd4194303;
      default: v = (i <= 6'd32) ? (36'd1 << (6'd32 - i)) : '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/sine_integral_trapezoid_simpson_unit.sv =====
// Integral of sin(x) between two limits by the composite trapezoid or
// composite Simpson rule.
// Input channel: in_tdata carries lower_limit, upper_limit (signed Q16.16)
// and intervals; in_tuser carries method (0 trapezoid, 1 Simpson).
// Output channel: out_tdata carries the integral (signed Q24.16) and the
// interval count used.
// One item is worked at a time. The block loads the item, divides the span
// by the panel count on a 54-step shared divider, then evaluates sine at
// count+1 points: range reduction by reciprocal multiply overlaps the
// 24-step CORDIC. A second division on the same divider and a shift-add
// multiply finish. When the count is zero, sine is sampled as for 2 panels
// (Simpson) or 1 panel (trapezoid).
// in_tready is high only while no item is in work; a finished result waits
// in the output register, so the next item is taken while the receiver
// stalls. A further result is held until that register is emptied.
// Reset (rst_n low, synchronous) drops any item in work and the pending
// result.
module sine_integral_trapezoid_simpson_unit import sits_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // lower_limit[31:0], upper_limit[63:32], intervals[79:64]
  input  logic [0:0]  in_tuser,   // method[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // integral[39:0], intervals_used[56:40], zero[63:57]
);

  sits_cmd_t        cmd;
  sits_stat_t       stat;
  logic [OUT_W-1:0] integral;
  logic [N_W-1:0]   intervals_used;

  sits_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sits_dp #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .lower_limit    ($signed(in_tdata[31:0])),
    .upper_limit    ($signed(in_tdata[63:32])),
    .intervals      (in_tdata[79:64]),
    .method         (in_tuser[0]),
    .stat           (stat),
    .integral       (integral),
    .intervals_used (intervals_used)
  );

  assign out_tdata = {7'd0, intervals_used, integral};

endmodule

// ===== hw/rtl/sits_div.sv =====
module sits_div import sits_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    busy,
  output logic signed [NUM_W-1:0] quo,
  output logic [DEN_W-1:0]        rem
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, fix_r, neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] den_r, rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W:0]   sh;
  logic             ge;

  assign sh = {rem_r, quo_r[NUM_W-1]};
  assign ge = sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      fix_r  <= 1'b0;
      cnt_r  <= '0;
      neg_r  <= num[NUM_W-1];
      quo_r  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      rem_r  <= '0;
      den_r  <= den;
    end else if (busy_r && !fix_r) begin
      rem_r <= ge ? DEN_W'(sh - {1'b0, den_r}) : DEN_W'(sh);
      quo_r <= {quo_r[NUM_W-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) fix_r <= 1'b1;
    end else if (busy_r) begin
      // turn truncated magnitude result into floor division
      if (neg_r) begin
        if (rem_r != '0) begin
          quo_r <= ~quo_r;
          rem_r <= den_r - rem_r;
        end else begin
          quo_r <= -quo_r;
        end
      end
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign quo  = $signed(quo_r);
  assign rem  = rem_r;

endmodule

// ===== hw/rtl/sits_sine.sv =====
module sits_sine import sits_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  red_start,
  input  logic signed [A_W-1:0] pt,
  input  logic [1:0]            wsh_in,
  input  logic                  cor_start,
  output logic                  red_busy,
  output logic                  buf_full,
  output logic                  cor_busy,
  output logic                  sine_vld,
  output logic signed [Z_W-1:0] sine,
  output logic [1:0]            wsh_out
);

  localparam int SH    = 32 - FRAC_BITS;
  localparam int XW    = A_W + SH;
  localparam int UW    = XW + 2;
  localparam int QW    = UW - 32;   // quotient bits
  localparam int RS    = 49 + SH;   // reciprocal scale
  localparam int RSW   = RS + 1;
  localparam int RW    = RS - 32;
  localparam int PW    = UW + SH;   // estimate product width
  localparam int CCW   = $clog2(CORDIC_STEPS + 1);
  localparam logic [UW-1:0] HP_TOP = UW'(HP_Q32) << SH;
  localparam logic [UW-1:0] HP_U   = UW'(HP_Q32);
  localparam logic [RW-1:0] RCP    = RW'((RSW'(1) << RS) / RSW'(HP_Q32));

  localparam logic [1:0] RP_EST = 2'd0;
  localparam logic [1:0] RP_SUB = 2'd1;
  localparam logic [1:0] RP_FIX = 2'd2;

  // range reduction
  logic             red_busy_r;
  logic [1:0]       rph_r;
  logic [UW-1:0]    u_r, u0, hq;
  logic [QW-1:0]    qe_r;
  logic [PW-1:0]    rprod;
  logic [1:0]       wred_r;
  logic signed [XW-1:0] xq;
  logic             ge, red_last;

  // hand-over buffer
  logic                  buf_full_r;
  logic signed [Z_W-1:0] zb_r;
  logic [1:0]            qmb_r, wb_r;

  // CORDIC
  logic                  cor_busy_r;
  logic [CCW-1:0]        ccnt_r;
  logic signed [Z_W-1:0] cx_r, cy_r, z_r, xs, ys;
  logic [Z_W-1:0]        at;
  logic [1:0]            qmc_r, wc_r;

  assign xq       = {pt, {SH{1'b0}}};
  assign u0       = UW'(xq) + UW'(HP_HALF) + HP_TOP;
  // estimate never exceeds the true quotient and falls short by at most three
  assign rprod    = PW'(u_r[UW-1:17]) * PW'(RCP);
  assign hq       = UW'(qe_r) * HP_U;
  assign ge       = u_r >= HP_U;
  assign red_last = red_busy_r && (rph_r == RP_FIX) && !ge;

  assign xs = cx_r >>> ccnt_r;
  assign ys = cy_r >>> ccnt_r;
  assign at = atan_q32(6'(ccnt_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_busy_r <= 1'b0;
      rph_r      <= RP_EST;
      buf_full_r <= 1'b0;
      cor_busy_r <= 1'b0;
      ccnt_r     <= '0;
    end else begin
      if (red_start) begin
        red_busy_r <= 1'b1;
        rph_r      <= RP_EST;
        u_r        <= u0;
        wred_r     <= wsh_in;
      end else if (red_busy_r) begin
        case (rph_r)
          RP_EST: begin
            qe_r  <= rprod[PW-1:32+SH];
            rph_r <= RP_SUB;
          end
          RP_SUB: begin
            u_r   <= u_r - hq;
            rph_r <= RP_FIX;
          end
          default: begin
            // step the estimate up to the exact quotient
            if (ge) begin
              u_r  <= u_r - HP_U;
              qe_r <= qe_r + 1'b1;
            end else begin
              red_busy_r <= 1'b0;
            end
          end
        endcase
      end

      if (red_last) begin
        buf_full_r <= 1'b1;
        zb_r       <= Z_W'(u_r[32:0]) - Z_W'(HP_HALF);
        qmb_r      <= qe_r[1:0];
        wb_r       <= wred_r;
      end else if (cor_start) begin
        buf_full_r <= 1'b0;
      end

      if (cor_start) begin
        cor_busy_r <= 1'b1;
        ccnt_r     <= '0;
        cx_r       <= INV_GAIN;
        cy_r       <= '0;
        z_r        <= zb_r;
        qmc_r      <= qmb_r;
        wc_r       <= wb_r;
      end else if (cor_busy_r) begin
        if (ccnt_r != CCW'(CORDIC_STEPS)) begin
          ccnt_r <= ccnt_r + 1'b1;
          if (!z_r[Z_W-1]) begin
            cx_r <= cx_r - ys;
            cy_r <= cy_r + xs;
            z_r  <= z_r - $signed(at);
          end else begin
            cx_r <= cx_r + ys;
            cy_r <= cy_r - xs;
            z_r  <= z_r + $signed(at);
          end
        end else begin
          cor_busy_r <= 1'b0;
        end
      end
    end
  end

  // quadrant picks the sine from the rotated vector
  always_comb begin
    case (qmc_r)
      2'd0:    sine = cy_r;
      2'd1:    sine = cx_r;
      2'd2:    sine = -cy_r;
      default: sine = -cx_r;
    endcase
  end

  assign sine_vld = cor_busy_r && (ccnt_r == CCW'(CORDIC_STEPS));
  assign wsh_out  = wc_r;
  assign red_busy = red_busy_r;
  assign buf_full = buf_full_r;
  assign cor_busy = cor_busy_r;

endmodule

// ===== hw/rtl/sits_dp.sv =====
module sits_dp import sits_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sits_cmd_t             cmd,
  input  logic signed [A_W-1:0] lower_limit,
  input  logic signed [A_W-1:0] upper_limit,
  input  logic [15:0]           intervals,
  input  logic                  method,
  output sits_stat_t            stat,
  output logic [OUT_W-1:0]      integral,
  output logic [N_W-1:0]        intervals_used
);

  logic signed [A_W-1:0] a_r;
  logic signed [D_W-1:0] d_r;
  logic [N_W-1:0]        used_r, neff_r, n_cl, used_c, neff_c;
  logic [DN_W-1:0]       den_r, den_c;
  logic                  simp_r;

  logic signed [PQ_W-1:0] q0_r, pq_r;
  logic [PR_W-1:0]        r0_r, pr_r, pr_sum, dstep;
  logic [I_W-1:0]         i_r;
  logic [1:0]             wsh;
  logic signed [A_W-1:0]  pt;

  logic signed [T_W-1:0] t_r;
  logic                  sine_vld;
  logic signed [Z_W-1:0] sine;
  logic [1:0]            wsh_out;
  logic                  red_busy, buf_full, cor_busy;

  logic signed [NUM_W-1:0] div_num, div_q;
  logic [DEN_W-1:0]        div_den, div_r;
  logic                    div_busy;

  logic                   mul_busy_r;
  logic [5:0]             mcnt_r;
  logic signed [P_W-1:0]  mcand_r, acc_r, madd, rnd;
  logic signed [D_W-1:0]  mplier_r;

  logic [OUT_W-1:0] integral_r;
  logic [N_W-1:0]   iused_r;

  // interval count bookkeeping
  always_comb begin
    n_cl   = (21'(intervals) > 21'(MAX_INTERVALS)) ? N_W'(MAX_INTERVALS) : N_W'(intervals);
    used_c = (method && n_cl[0]) ? n_cl + 1'b1 : n_cl;
    if (used_c != '0) neff_c = used_c;
    else              neff_c = method ? N_W'(2) : N_W'(1);
    den_c  = method ? DN_W'(neff_c) + (DN_W'(neff_c) << 1) : DN_W'(neff_c) << 1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r    <= lower_limit;
      d_r    <= D_W'(upper_limit) - D_W'(lower_limit);
      used_r <= used_c;
      neff_r <= neff_c;
      den_r  <= den_c;
      simp_r <= method;
    end
  end

  // step division, then mean division, share one divider
  assign div_num = cmd.div_mean ? (NUM_W'(t_r) <<< 1) + $signed(NUM_W'(den_r))
                                : NUM_W'(d_r) <<< 1;
  assign div_den = cmd.div_mean ? DEN_W'(den_r) << 1 : DEN_W'(neff_r) << 1;

  sits_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_step | cmd.div_mean),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_q),
    .rem   (div_r)
  );

  // sample points: lower + round(i*d/n), advanced by quotient and remainder
  assign dstep  = PR_W'(neff_r) << 1;
  assign pr_sum = pr_r + r0_r;
  assign pt     = A_W'(PQ_W'(a_r) + pq_r);

  always_comb begin
    if (i_r == '0 || i_r == I_W'(neff_r)) wsh = 2'd0;
    else if (simp_r && i_r[0])            wsh = 2'd2;
    else                                  wsh = 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
    end else if (cmd.pt_init) begin
      q0_r <= div_q[PQ_W-1:0];
      r0_r <= PR_W'(div_r);
      pq_r <= '0;
      pr_r <= PR_W'(neff_r);
      i_r  <= '0;
    end else if (cmd.red_start) begin
      i_r <= i_r + 1'b1;
      if (pr_sum >= dstep) begin
        pr_r <= pr_sum - dstep;
        pq_r <= pq_r + q0_r + PQ_W'(1);
      end else begin
        pr_r <= pr_sum;
        pq_r <= pq_r + q0_r;
      end
    end
  end

  sits_sine #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_sine (
    .clk       (clk),
    .rst_n     (rst_n),
    .red_start (cmd.red_start),
    .pt        (pt),
    .wsh_in    (wsh),
    .cor_start (cmd.cor_start),
    .red_busy  (red_busy),
    .buf_full  (buf_full),
    .cor_busy  (cor_busy),
    .sine_vld  (sine_vld),
    .sine      (sine),
    .wsh_out   (wsh_out)
  );

  always_ff @(posedge clk) begin
    if (cmd.pt_init)   t_r <= '0;
    else if (sine_vld) t_r <= t_r + (T_W'(sine) <<< wsh_out);
  end

  // shift-add multiply of the mean by the span, top bit of span weighs negative
  assign madd = mplier_r[0] ? ((mcnt_r == 6'(D_W - 1)) ? -mcand_r : mcand_r) : '0;
  assign rnd  = acc_r + P_W'(64'sd2147483648);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      mcnt_r     <= '0;
    end else if (cmd.mul_start) begin
      mul_busy_r <= 1'b1;
      mcnt_r     <= '0;
      mcand_r    <= P_W'($signed(div_q[M_W-1:0]));
      mplier_r   <= d_r;
      acc_r      <= '0;
    end else if (mul_busy_r) begin
      acc_r    <= acc_r + madd;
      mcand_r  <= mcand_r <<< 1;
      mplier_r <= mplier_r >>> 1;
      mcnt_r   <= mcnt_r + 1'b1;
      if (mcnt_r == 6'(D_W - 1)) mul_busy_r <= 1'b0;
    end
  end

  // rounded product always lies inside the 40-bit range
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      integral_r <= OUT_W'($signed(rnd[P_W-1:32]));
      iused_r    <= used_r;
    end
  end

  assign integral       = integral_r;
  assign intervals_used = iused_r;

  assign stat.div_busy   = div_busy;
  assign stat.red_busy   = red_busy;
  assign stat.buf_full   = buf_full;
  assign stat.cor_busy   = cor_busy;
  assign stat.all_issued = i_r > I_W'(neff_r);
  assign stat.mul_busy   = mul_busy_r;

endmodule

// ===== hw/rtl/sits_ctrl.sv =====
`include "assert_macros.svh"

module sits_ctrl import sits_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  sits_stat_t stat,
  output sits_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_STEP      = 3'd1;
  localparam logic [2:0] S_STEP_WAIT = 3'd2;
  localparam logic [2:0] S_SAMPLE    = 3'd3;
  localparam logic [2:0] S_MEAN      = 3'd4;
  localparam logic [2:0] S_MEAN_WAIT = 3'd5;
  localparam logic [2:0] S_MUL_WAIT  = 3'd6;
  localparam logic [2:0] S_DONE      = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       sample_end;

  assign sample_end = stat.all_issued && !stat.red_busy && !stat.buf_full && !stat.cor_busy;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_tvalid;
        if (in_tvalid) state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.div_step = 1'b1;
        state_nxt    = S_STEP_WAIT;
      end
      S_STEP_WAIT: begin
        if (!stat.div_busy) begin
          cmd.pt_init = 1'b1;
          state_nxt   = S_SAMPLE;
        end
      end
      S_SAMPLE: begin
        // reduce the next point while the CORDIC works on this one
        cmd.red_start = !stat.red_busy && !stat.buf_full && !stat.all_issued;
        cmd.cor_start = !stat.cor_busy && stat.buf_full;
        if (sample_end) state_nxt = S_MEAN;
      end
      S_MEAN: begin
        cmd.div_mean = 1'b1;
        state_nxt    = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (!stat.div_busy) begin
          cmd.mul_start = 1'b1;
          state_nxt     = S_MUL_WAIT;
        end
      end
      S_MUL_WAIT: begin
        if (!stat.mul_busy) state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load)    out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  `SITS_ASSERT_IMPL(a_div_free, cmd.div_step || cmd.div_mean, !stat.div_busy)
  `SITS_ASSERT_IMPL(a_sample_done, state_r == S_MEAN && $past(state_r) == S_SAMPLE,
                    stat.all_issued && !stat.cor_busy && !stat.buf_full)
  `SITS_ASSERT_IMPL(a_idle_quiet, in_tready,
                    !stat.div_busy && !stat.mul_busy && !stat.cor_busy && !stat.red_busy)
  `SITS_ASSERT_NEXT(a_mul_runs, cmd.mul_start, stat.mul_busy)

endmodule

// ===== dv/sine_integral_trapezoid_simpson_unit_tb.sv =====
`timescale 1ns / 100ps

module sine_integral_trapezoid_simpson_unit_tb;
  import sits_pkg::*;

  localparam longint HALF_PI   = 64'sd6746518852;
  localparam longint GAIN_INV  = 64'sd2608131496;
  localparam longint SAT_MAX   = 64'sd549755813887;
  localparam int     N_STEPS   = 24;
  localparam longint CYC_LIMIT = 64'd8000000;
  localparam bit     TRAP      = 1'b0;
  localparam bit     SIMP      = 1'b1;

  localparam longint ARC_TAB [0:10] = '{
    64'sd3373259426, 64'sd1991351318, 64'sd1052175346, 64'sd534100635,
    64'sd268086748, 64'sd134174063, 64'sd67103403, 64'sd33553749,
    64'sd16777131, 64'sd8388597, 64'sd4194303};

  typedef struct {
    logic signed [31:0] lo_lim;
    logic signed [31:0] hi_lim;
    logic [15:0]        panels;
    bit                 rule;
    bit                 typed;      // expectation written in the row
    logic signed [39:0] area_typ;
    logic [16:0]        used_typ;
  } job_t;

  typedef struct {
    logic signed [39:0] area;
    logic [16:0]        used;
  } area_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;

  area_t  area_q[$];
  int     n_err = 0;
  int     n_seen = 0;
  int     n_sent = 0;
  longint cycles = 0;
  bit     calm = 1'b0;

  sine_integral_trapezoid_simpson_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #10 clk = ~clk;

  function automatic longint div_floor(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && ((num < 0) != (den < 0))) q--;
    return q;
  endfunction

  function automatic longint div_round(longint num, longint den);
    return div_floor(2 * num + den, 2 * den);
  endfunction

  function automatic longint sine_at(longint pt);
    longint xq, quad, ang, cx, cy, xs, ys, arc;
    xq = pt * 65536;
    quad = div_floor(xq + HALF_PI / 2, HALF_PI);
    ang = xq - quad * HALF_PI;
    cx = GAIN_INV;
    cy = 0;
    for (int i = 0; i < N_STEPS; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      arc = (i < 11) ? ARC_TAB[i] : (64'sd1 <<< (32 - i));
      if (ang >= 0) begin
        cx -= ys; cy += xs; ang -= arc;
      end else begin
        cx += ys; cy -= xs; ang += arc;
      end
    end
    case (quad & 3)
      0: return cy;
      1: return cx;
      2: return -cy;
      default: return -cx;
    endcase
  endfunction

  function automatic area_t integrate(job_t j);
    area_t  res;
    longint a, span, n, used, neff, acc, mean, sh, sl, prod;
    a = j.lo_lim;
    span = longint'(j.hi_lim) - a;
    n = j.panels;
    if (n > MAX_INTERVALS) n = MAX_INTERVALS;
    used = n;
    if (j.rule == SIMP && used[0]) used++;
    neff = (used != 0) ? used : ((j.rule == SIMP) ? 2 : 1);
    acc = sine_at(a) + sine_at(j.hi_lim);
    for (longint i = 1; i < neff; i++) begin
      if (j.rule == SIMP && i[0]) acc += 4 * sine_at(a + div_round(i * span, neff));
      else acc += 2 * sine_at(a + div_round(i * span, neff));
    end
    mean = div_round(acc, (j.rule == SIMP) ? 3 * neff : 2 * neff);
    sh = span >>> 16;
    sl = span - sh * 65536;
    prod = (mean * sh + ((mean * sl + (64'sd1 <<< 31)) >>> 16)) >>> 16;
    if (prod > SAT_MAX) prod = SAT_MAX;
    if (prod < -SAT_MAX - 1) prod = -SAT_MAX - 1;
    res.area = prod[39:0];
    res.used = used[16:0];
    return res;
  endfunction

  function automatic job_t mk(logic [31:0] a, logic [31:0] b, logic [15:0] n, bit r);
    job_t j;
    j.lo_lim = a; j.hi_lim = b; j.panels = n; j.rule = r;
    j.typed = 1'b0; j.area_typ = '0; j.used_typ = '0;
    return j;
  endfunction

  function automatic job_t mk_typed(logic [31:0] a, logic [15:0] n, bit r, logic [16:0] u);
    job_t j;
    j = mk(a, a, n, r);
    j.typed = 1'b1;
    j.used_typ = u;
    return j;
  endfunction

  task automatic send_job(job_t j);
    area_t want;
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {j.panels, j.hi_lim, j.lo_lim};
    in_tuser = j.rule;
    do @(posedge clk); while (!in_tready);
    if (j.typed) begin
      want.area = j.area_typ;
      want.used = j.used_typ;
    end else begin
      want = integrate(j);
    end
    area_q.push_back(want);
    n_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // receiver back-pressure in bursts
  initial begin
    forever begin
      @(negedge clk);
      if (calm || $urandom_range(0, 3) != 0) begin
        out_tready = 1'b1;
        repeat ($urandom_range(0, 20)) @(negedge clk);
      end else begin
        out_tready = 1'b0;
        repeat ($urandom_range(0, 13)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    area_t want;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      n_seen++;
      if (area_q.size() == 0) begin
        $error("integral result with no item outstanding");
        n_err++;
      end else begin
        want = area_q.pop_front();
        if (out_tdata[39:0] !== want.area) begin
          $error("integral: expected %0d, got %0d", want.area, $signed(out_tdata[39:0]));
          n_err++;
        end
        if (out_tdata[56:40] !== want.used) begin
          $error("intervals_used: expected %0d, got %0d", want.used, out_tdata[56:40]);
          n_err++;
        end
      end
    end
  end

  initial begin
    wait (cycles >= CYC_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    job_t   rows[$];
    job_t   j;
    int     pick;
    logic [31:0] a, b;
    // zero span always gives zero area, whatever the sine samples
    rows.push_back(mk_typed(32'h0000_0000, 16'd0, TRAP, 17'd0));
    rows.push_back(mk_typed(32'h0005_0000, 16'd0, SIMP, 17'd0));
    rows.push_back(mk_typed(32'hFFFF_FFFF, 16'd3, SIMP, 17'd4));
    rows.push_back(mk_typed(32'h8000_0000, 16'd1, SIMP, 17'd2));
    rows.push_back(mk_typed(32'h7FFF_FFFF, 16'd7, TRAP, 17'd7));
    rows.push_back(mk(32'h0000_0000, 32'h0003_243F, 16'd16, TRAP));
    rows.push_back(mk(32'h0000_0000, 32'h0003_243F, 16'd16, SIMP));
    rows.push_back(mk(32'h0000_0000, 32'h0003_243F, 16'd7, SIMP));
    rows.push_back(mk(32'h0003_243F, 32'h0000_0000, 16'd8, TRAP));
    rows.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, 16'd1, TRAP));
    rows.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 16'd2, SIMP));
    rows.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, 16'd0, TRAP));
    rows.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 16'd0, SIMP));
    rows.push_back(mk(32'hFFFF_0000, 32'h0001_0000, 16'd5, TRAP));
    rows.push_back(mk(32'hFFF0_0000, 32'h0010_0000, 16'd33, SIMP));
    rows.push_back(mk(32'h0000_0000, 32'h0001_0000, 16'hFFFF, SIMP));

    in_tvalid = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[k]) send_job(rows[k]);

    for (int k = 0; k < 90; k++) begin
      if (k >= 70) calm = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        a = $urandom_range(0, 1310720) - 655360;
        b = $urandom_range(0, 1310720) - 655360;
      end else if (pick < 8) begin
        a = $urandom();
        b = $urandom();
      end else begin
        a = $urandom();
        b = a + $urandom_range(0, 262144) - 131072;
      end
      j = mk(a, b, ($urandom_range(0, 7) == 0) ? 16'($urandom_range(41, 300))
                                               : 16'($urandom_range(0, 40)),
             1'($urandom_range(0, 1)));
      send_job(j);
    end

    while (area_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d integration requests (trapezoid and Simpson, directed then random),",
             n_sent);
    $display("checked %0d results, %0d mismatches.", n_seen, n_err);
    if (n_err == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/sits_pkg.sv
hw/rtl/sits_div.sv
hw/rtl/sits_sine.sv
hw/rtl/sits_dp.sv
hw/rtl/sits_ctrl.sv
hw/rtl/sine_integral_trapezoid_simpson_unit.sv
dv/sine_integral_trapezoid_simpson_unit_tb.sv
